FILE: hdl/mandelbrot_escape_time_pixel_macros.svh
// ---------------------------------------------------------------------------
// Mandelbrot escape-time pixel: assertion macros
// Shared assertion forms, clocked on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// Same-cycle implication
`define MBROT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MBROT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mbrot_pkg.sv
// ---------------------------------------------------------------------------
// mbrot_pkg
// Constants shared by the escape-time pixel block and its channel interfaces.
// ---------------------------------------------------------------------------
package mbrot_pkg;

  // Default parameter values
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 28;
  localparam int COUNT_BITS_DEF = 16;

  // Configuration register widths
  localparam int DIM_BITS       = 13;
  localparam int LIMIT_BITS     = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_ROWS      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_COLUMNS   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ITERATION_LIMIT = 2'd2;

  // Reset values
  localparam logic [DIM_BITS-1:0]   IMAGE_ROWS_RST      = 13'd64;
  localparam logic [DIM_BITS-1:0]   IMAGE_COLUMNS_RST   = 13'd64;
  localparam logic [LIMIT_BITS-1:0] ITERATION_LIMIT_RST = 16'd256;

endpackage

FILE: hdl/mbrot_if.sv
// ---------------------------------------------------------------------------
// mbrot channel interfaces
// Valid/ready channels for pixel coordinates in and escape results out.
// ---------------------------------------------------------------------------
interface mbrot_pixel_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] row_index;
  logic [COORD_BITS-1:0] column_index;

  modport source (output valid, row_index, column_index, input ready);
  modport sink   (input valid, row_index, column_index, output ready);
endinterface

interface mbrot_result_if #(
  parameter int COUNT_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  inside_set;
  logic [COUNT_BITS-1:0] iteration_count;

  modport source (output valid, inside_set, iteration_count, input ready);
  modport sink   (input valid, inside_set, iteration_count, output ready);
endinterface

FILE: hdl/mandelbrot_escape_time_pixel.sv
// ---------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time count for one pixel of the Mandelbrot set in signed fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   pixel  : valid/ready channel carrying row_index and column_index. One
//            transaction is accepted only while the block is idle.
//   result : valid/ready channel carrying inside_set and iteration_count,
//            held in an output register until the receiver takes it.
//   cfg    : write-only port; the user writes image_rows, image_columns and
//            iteration_limit only while idle; the block does not enforce it.
// Sequence: two restoring divisions (COORD_BITS+FRAC_BITS+1 steps each, each
//   followed by a mapping state) set the coordinates. Each z = z*z + c step
//   passes S_MUL_RR, S_MUL_II and S_CHECK, sharing the one multiplier, then
//   S_UPDATE; once z escapes or the count reaches the limit, S_CHECK goes on
//   to S_EMIT instead.
// Throughput: one pixel at a time; ready returns at the same edge that
//   loads the result into the output register.
// Reset: rst (synchronous) returns the sequencer to idle, empties the output
//   register and restores the configuration defaults (64, 64, 256).
// Stall: a finished result waits in the sequencer until the output register
//   is free, and no new pixel is taken meanwhile.
// ---------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_macros.svh"

module mandelbrot_escape_time_pixel
  import mbrot_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  mbrot_pixel_if.sink               pixel,
  mbrot_result_if.source            result,
  input  logic                      cfg_write_enable,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Widths: z values, products, dividend/quotient, step counter
  localparam int ZW      = FRAC_BITS + 4;
  localparam int PW      = 2 * ZW;
  localparam int DW      = COORD_BITS + FRAC_BITS + 1;
  localparam int CW      = $clog2(DW);
  localparam int LIM_EXT = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

  localparam logic signed [PW-1:0] FX_MAX = PW'((64'sd1 <<< (FRAC_BITS + 3)) - 64'sd1);
  localparam logic signed [PW-1:0] FX_MIN = -PW'(64'sd1 <<< (FRAC_BITS + 3));
  localparam logic        [PW-1:0] FOUR   = PW'(1) << (2 * FRAC_BITS + 2);
  localparam logic signed [DW:0]   Q_MAX  = (DW + 1)'((64'sd1 <<< (FRAC_BITS + 3)) - 64'sd1);
  localparam logic signed [DW:0]   OFF_RE = (DW + 1)'(64'sd3 <<< (FRAC_BITS - 1));
  localparam logic signed [DW:0]   OFF_IM = (DW + 1)'(64'sd1 <<< FRAC_BITS);
  localparam logic        [CW-1:0] LAST_STEP = CW'(DW - 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV    = 8'b0000_0010,
    S_MAP    = 8'b0000_0100,
    S_MUL_RR = 8'b0000_1000,
    S_MUL_II = 8'b0001_0000,
    S_CHECK  = 8'b0010_0000,
    S_UPDATE = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  // Saturate a wide signed value to the z range
  function automatic logic signed [ZW-1:0] sat_z(input logic signed [PW-1:0] v);
    if (v > FX_MAX) return FX_MAX[ZW-1:0];
    if (v < FX_MIN) return FX_MIN[ZW-1:0];
    return v[ZW-1:0];
  endfunction

  state_t state;

  // Configuration registers
  logic [DIM_BITS-1:0]   image_rows;
  logic [DIM_BITS-1:0]   image_columns;
  logic [LIMIT_BITS-1:0] iteration_limit;

  // Captured pixel row
  logic [COORD_BITS-1:0] row_q;

  // Divider
  logic                div_sel;   // 0: real (column), 1: imaginary (row)
  logic [DW-1:0]       div_num;
  logic [DIM_BITS-1:0] div_rem;
  logic [DW-1:0]       div_quo;
  logic [CW-1:0]       div_cnt;

  // Iteration state
  logic signed [ZW-1:0] cr, ci, zr, zi;
  logic signed [PW-1:0] rr, ii, ri, diff;
  logic [COUNT_BITS-1:0] n;

  // Output register
  logic                  out_valid;
  logic                  out_inside;
  logic [COUNT_BITS-1:0] out_count;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows      <= IMAGE_ROWS_RST;
      image_columns   <= IMAGE_COLUMNS_RST;
      iteration_limit <= ITERATION_LIMIT_RST;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        CFG_IMAGE_ROWS:      image_rows      <= cfg_data[DIM_BITS-1:0];
        CFG_IMAGE_COLUMNS:   image_columns   <= cfg_data[DIM_BITS-1:0];
        CFG_ITERATION_LIMIT: iteration_limit <= cfg_data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective limit at counter width
  logic [LIM_EXT-1:0]    limit_ext;
  logic [COUNT_BITS-1:0] limit;
  assign limit_ext = LIM_EXT'(iteration_limit);
  assign limit     = limit_ext[COUNT_BITS-1:0];

  // Divider step: restoring, one quotient bit per cycle; zero divisor counts as 1
  logic [DIM_BITS-1:0] dvs_raw, dvs;
  logic [DIM_BITS:0]   trial;
  logic                trial_ge;
  logic [DIM_BITS:0]   trial_sub;
  assign dvs_raw   = div_sel ? image_rows : image_columns;
  assign dvs       = (dvs_raw == '0) ? DIM_BITS'(1) : dvs_raw;
  assign trial     = {div_rem, div_num[DW-1]};
  assign trial_ge  = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};

  // Quotient minus offset, saturated at the top (never below the bottom)
  logic signed [DW:0]   q_off;
  logic signed [ZW-1:0] coord;
  assign q_off = $signed({1'b0, div_quo}) - (div_sel ? OFF_IM : OFF_RE);
  assign coord = (q_off > Q_MAX) ? Q_MAX[ZW-1:0] : q_off[ZW-1:0];

  // Shared multiplier
  logic signed [ZW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  assign mul_a = (state == S_MUL_II) ? zi : zr;
  assign mul_b = (state == S_MUL_RR) ? zr : zi;
  assign mul_p = mul_a * mul_b;

  // Escape test and counter
  logic [PW-1:0]         mag2;
  logic                  escaped;
  logic [COUNT_BITS-1:0] n_inc;
  assign mag2    = $unsigned(rr) + $unsigned(ii);
  assign escaped = mag2 >= FOUR;
  assign n_inc   = n + 1'b1;

  // z update, floor shift then add c
  logic signed [PW-1:0] nr_wide, ni_wide;
  assign nr_wide = (diff >>> FRAC_BITS) + PW'(cr);
  assign ni_wide = (ri >>> (FRAC_BITS - 1)) + PW'(ci);

  logic out_free;
  assign out_free = !out_valid || result.ready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (pixel.valid) state <= S_DIV;
        S_DIV:    if (div_cnt == LAST_STEP) state <= S_MAP;
        S_MAP:    state <= div_sel ? S_MUL_RR : S_DIV;
        S_MUL_RR: state <= S_MUL_II;
        S_MUL_II: state <= S_CHECK;
        S_CHECK:  state <= (escaped || n_inc >= limit) ? S_EMIT : S_UPDATE;
        S_UPDATE: state <= S_MUL_RR;
        S_EMIT:   if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        row_q   <= pixel.row_index;
        div_sel <= 1'b0;
        div_num <= {pixel.column_index, {(FRAC_BITS + 1){1'b0}}};
        div_rem <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        div_rem <= trial_ge ? trial_sub[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
        div_quo <= {div_quo[DW-2:0], trial_ge};
        div_num <= div_num << 1;
        div_cnt <= div_cnt + 1'b1;
      end
      S_MAP: begin
        if (div_sel) begin
          ci <= coord;
          zr <= '0;
          zi <= '0;
          n  <= '0;
        end else begin
          cr      <= coord;
          div_sel <= 1'b1;
          div_num <= {row_q, {(FRAC_BITS + 1){1'b0}}};
          div_rem <= '0;
          div_cnt <= '0;
        end
      end
      S_MUL_RR: rr <= mul_p;
      S_MUL_II: ii <= mul_p;
      S_CHECK: begin
        ri   <= mul_p;
        diff <= rr - ii;
        if (!escaped) n <= n_inc;
      end
      S_UPDATE: begin
        zr <= sat_z(nr_wide);
        zi <= sat_z(ni_wide);
      end
      S_EMIT: ;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_count  <= n;
      out_inside <= (n == limit);
    end
  end

  assign pixel.ready            = (state == S_IDLE);
  assign result.valid           = out_valid;
  assign result.inside_set      = out_inside;
  assign result.iteration_count = out_count;

  // Checks
  `MBROT_ASSERT_IMP(a_count_below_limit, state == S_CHECK, (n < limit) || (limit == '0),
    "counter reached the limit without stopping")
  `MBROT_ASSERT_IMP(a_update_bounded, state == S_UPDATE, mag2 < FOUR,
    "z updated after escape")
  `MBROT_ASSERT_NXT(a_iter_start_clear, (state == S_MAP) && div_sel,
    (zr == '0) && (zi == '0) && (n == '0), "iteration did not start from zero")
  `MBROT_ASSERT_IMP(a_inside_at_limit, result.valid && result.inside_set,
    result.iteration_count == limit, "inside flag without the count at the limit")

endmodule

FILE: verif/mbrot_escape_checker.sv
// ---------------------------------------------------------------------------
// mbrot_escape_checker
// Watches the pixel, result and configuration ports of the escape-time block,
// works out the expected count for every accepted pixel and compares each
// returned result against the oldest outstanding expectation.
// ---------------------------------------------------------------------------
module mbrot_escape_checker
  import mbrot_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  mbrot_pixel_if                    pixel,
  mbrot_result_if                   result,
  input  logic                      cfg_write_enable,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        error_count,
  output int                        pending_count,
  output int                        checked_count,
  output int                        inside_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = FRAC_BITS_DEF;

  // Q4 fixed point bounds and constants, held in 64 bits
  localparam longint FX_MAX     = (64'sd1 <<< (FRAC_BITS + 3)) - 64'sd1;
  localparam longint FX_MIN     = -(64'sd1 <<< (FRAC_BITS + 3));
  localparam longint FX_ONE     = 64'sd1 <<< FRAC_BITS;
  localparam longint FX_ONE_5   = FX_ONE + (FX_ONE >>> 1);
  localparam logic [63:0] ESCAPE_RADIUS_SQ = 64'd4 << (2 * FRAC_BITS);
  localparam logic [63:0] QUOTIENT_CLAMP   = 64'd1 << 40;

  typedef struct packed {
    logic                      inside_set;
    logic [COUNT_BITS_DEF-1:0] iteration_count;
  } escape_t;

  // Shadow of the configuration registers
  logic [DIM_BITS-1:0]   image_rows;
  logic [DIM_BITS-1:0]   image_columns;
  logic [LIMIT_BITS-1:0] iteration_limit;

  escape_t escape_q[$];

  function automatic longint clamp_q4(input longint v);
    if (v > FX_MAX) return FX_MAX;
    if (v < FX_MIN) return FX_MIN;
    return v;
  endfunction

  // Pixel index to fixed point coordinate; a zero divisor acts as one
  function automatic longint pixel_to_coord(input logic [COORD_BITS_DEF-1:0] index,
                                            input logic [DIM_BITS-1:0] divisor,
                                            input longint offset);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    num = 64'(index) << (FRAC_BITS + 1);
    den = (divisor == '0) ? 64'd1 : 64'(divisor);
    quo = num / den;
    if (quo > QUOTIENT_CLAMP) quo = QUOTIENT_CLAMP;
    return clamp_q4($signed(quo) - offset);
  endfunction

  // Escape-time iteration for one pixel under the current settings
  function automatic escape_t escape_time(input logic [COORD_BITS_DEF-1:0] row,
                                          input logic [COORD_BITS_DEF-1:0] col);
    longint      cr, ci, zr, zi, rr, ii, nr, ni;
    int unsigned n;
    bit          done;
    escape_t     res;
    cr   = pixel_to_coord(col, image_columns, FX_ONE_5);
    ci   = pixel_to_coord(row, image_rows, FX_ONE);
    zr   = 0;
    zi   = 0;
    n    = 0;
    done = 1'b0;
    while (!done) begin
      rr = zr * zr;
      ii = zi * zi;
      if ($unsigned(rr) + $unsigned(ii) >= ESCAPE_RADIUS_SQ) begin
        done = 1'b1;
      end else begin
        n++;
        if (n >= iteration_limit) begin
          done = 1'b1;
        end else begin
          nr = ((rr - ii) >>> FRAC_BITS) + cr;
          ni = ((2 * zr * zi) >>> FRAC_BITS) + ci;
          zr = clamp_q4(nr);
          zi = clamp_q4(ni);
        end
      end
    end
    res.inside_set      = (n == iteration_limit);
    res.iteration_count = n[COUNT_BITS_DEF-1:0];
    return res;
  endfunction

  // Track configuration, queue predictions, compare results
  always @(posedge clk) begin : monitor
    escape_t want;
    if (rst) begin
      image_rows      = IMAGE_ROWS_RST;
      image_columns   = IMAGE_COLUMNS_RST;
      iteration_limit = ITERATION_LIMIT_RST;
      escape_q.delete();
      error_count     = 0;
      checked_count   = 0;
      inside_count    = 0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          CFG_IMAGE_ROWS:      image_rows      = cfg_data[DIM_BITS-1:0];
          CFG_IMAGE_COLUMNS:   image_columns   = cfg_data[DIM_BITS-1:0];
          CFG_ITERATION_LIMIT: iteration_limit = cfg_data[LIMIT_BITS-1:0];
          default: ;
        endcase
      end
      if (pixel.valid && pixel.ready)
        escape_q.push_back(escape_time(pixel.row_index, pixel.column_index));
      if (result.valid && result.ready) begin
        if (escape_q.size() == 0) begin
          $error("unexpected result transaction: inside_set %0d, iteration_count %0d",
                 result.inside_set, result.iteration_count);
          error_count++;
        end else begin
          want = escape_q.pop_front();
          if (result.inside_set !== want.inside_set) begin
            $error("inside_set: expected %0d, got %0d", want.inside_set, result.inside_set);
            error_count++;
          end
          if (result.iteration_count !== want.iteration_count) begin
            $error("iteration_count: expected %0d, got %0d",
                   want.iteration_count, result.iteration_count);
            error_count++;
          end
          checked_count++;
          if (want.inside_set) inside_count++;
        end
      end
    end
    pending_count = escape_q.size();
  end

endmodule

FILE: verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Mandelbrot escape-time pixel block: directed
// corner pixels and settings, then randomised phases of pixels with random
// idling on both channels and one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb;
  import mbrot_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;  // no register here

  localparam int RANDOM_PHASES   = 9;
  localparam int PIXELS_PER_PHASE = 200;
  localparam int HOLD_AFTER      = 400;
  localparam int HOLD_CYCLES     = 4000;
  localparam int IDLE_LIMIT      = 1000000;
  localparam int SETTLE_CYCLES   = 200;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write_enable;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  int errors, pending, checked, inside_total;
  int sent_count   = 0;
  int settings     = 0;
  int idle_cycles  = 0;
  bit quiet        = 1'b0;
  bit held_off     = 1'b0;

  mbrot_pixel_if  #(.COORD_BITS(COORD_BITS_DEF)) pixel_ch ();
  mbrot_result_if #(.COUNT_BITS(COUNT_BITS_DEF)) result_ch ();

  mandelbrot_escape_time_pixel dut (
    .clk              (clk),
    .rst              (rst),
    .pixel            (pixel_ch),
    .result           (result_ch),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  mbrot_escape_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .pixel            (pixel_ch),
    .result           (result_ch),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .error_count      (errors),
    .pending_count    (pending),
    .checked_count    (checked),
    .inside_count     (inside_total)
  );

  always #5ns clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // Image size written with the spare upper data bits sometimes set
  function automatic logic [CFG_DATA_BITS-1:0] random_dim();
    int unsigned r;
    logic [DIM_BITS-1:0] dim;
    r = $urandom_range(0, 99);
    if (r < 8)       dim = '0;
    else if (r < 45) dim = DIM_BITS'($urandom_range(1, 64));
    else if (r < 85) dim = DIM_BITS'($urandom_range(65, 4096));
    else             dim = DIM_BITS'($urandom_range(4097, 8191));
    if ($urandom_range(0, 3) == 0)
      return {3'($urandom), dim};
    return {3'b000, dim};
  endfunction

  // Limits kept modest so the run stays short
  function automatic logic [CFG_DATA_BITS-1:0] random_limit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return CFG_DATA_BITS'($urandom_range(0, 3));
    if (r < 90) return CFG_DATA_BITS'($urandom_range(4, 40));
    return CFG_DATA_BITS'($urandom_range(41, 160));
  endfunction

  // Mostly inside the image, sometimes anywhere in the index range
  function automatic logic [COORD_BITS_DEF-1:0] random_index(input logic [DIM_BITS-1:0] dim);
    int unsigned span;
    span = (dim == '0 || dim > 4096) ? 4096 : dim;
    if ($urandom_range(0, 4) == 0) return COORD_BITS_DEF'($urandom);
    return COORD_BITS_DEF'($urandom_range(0, span - 1));
  endfunction

  task automatic send_pixel(input logic [COORD_BITS_DEF-1:0] row,
                            input logic [COORD_BITS_DEF-1:0] col);
    int unsigned gap;
    gap = quiet ? 0 : idle_gap();
    @(negedge clk);
    if (gap != 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_ch.valid        <= 1'b1;
    pixel_ch.row_index    <= row;
    pixel_ch.column_index <= col;
    do @(posedge clk); while (!pixel_ch.ready);
    sent_count++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_block();
    @(negedge clk);
    pixel_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= data;
  endtask

  task automatic apply_config(input logic [CFG_DATA_BITS-1:0] rows_w,
                              input logic [CFG_DATA_BITS-1:0] cols_w,
                              input logic [CFG_DATA_BITS-1:0] limit_w,
                              input bit touch_spare);
    if (touch_spare) write_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));
    write_reg(CFG_IMAGE_ROWS, rows_w);
    write_reg(CFG_IMAGE_COLUMNS, cols_w);
    write_reg(CFG_ITERATION_LIMIT, limit_w);
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    settings++;
  endtask

  // Result side: random stalls, quiet stretches and one long hold-off
  initial begin : result_stall
    int unsigned stall_left;
    stall_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && sent_count >= HOLD_AFTER) begin
        held_off = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left != 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
        stall_left = quiet ? 0 : idle_gap();
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_BITS-1:0] rows_w, cols_w;
    rst                   = 1'b1;
    pixel_ch.valid        = 1'b0;
    pixel_ch.row_index    = '0;
    pixel_ch.column_index = '0;
    cfg_write_enable      = 1'b0;
    cfg_index             = CFG_IMAGE_ROWS;
    cfg_data              = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: corners, saturated mapping, points inside, bit patterns
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd32, 12'd32);
    send_pixel(12'd32, 12'd48);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd16, 12'd16);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    drain_block();

    // Zero image sizes act as one; a limit of one stops at the first count
    apply_config(16'd0, 16'd0, 16'd1, 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    drain_block();

    // Limit of zero: count one, never inside; c = 0 at row 2048, column 3072
    apply_config(16'd4096, 16'd4096, 16'd0, 1'b0);
    send_pixel(12'd2048, 12'd3072);
    send_pixel(12'd0, 12'd0);
    drain_block();

    // Largest limit with c = 0; upper data bits of a size write are dropped
    apply_config(16'hE002, 16'd4, 16'hFFFF, 1'b0);
    send_pixel(12'd1, 12'd3);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd0, 12'd4095);
    drain_block();

    // Largest image sizes, a write to the unused index alongside
    apply_config(16'd8191, 16'd8191, 16'd2, 1'b1);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    drain_block();

    // Random phases, each under its own settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      rows_w = random_dim();
      cols_w = random_dim();
      apply_config(rows_w, cols_w, random_limit(), $urandom_range(0, 2) == 0);
      for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) < 2) quiet = !quiet;
        send_pixel(random_index(rows_w[DIM_BITS-1:0]), random_index(cols_w[DIM_BITS-1:0]));
      end
      drain_block();
    end
    quiet = 1'b0;

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d pixels under %0d register settings", sent_count, settings + 1);
    $display("%0d results checked, %0d of them inside the set", checked, inside_total);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
